@@ rtl/core/ptp_pkg.sv @@
// Package for the pixel tone and hue posterizer.
// Pixel and configuration types, register indexes, reset values and thresholds.
// No dependencies.
package ptp_pkg;

  localparam int ChanW   = 8;
  localparam int RgbW    = 3 * ChanW;
  localparam int SumW    = 10;
  localparam int CfgAddrW = 3;

  // register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] RegMargin  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegYellow  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegMagenta = 3'd2;
  localparam logic [CfgAddrW-1:0] RegCyan    = 3'd3;
  localparam logic [CfgAddrW-1:0] RegRed     = 3'd4;
  localparam logic [CfgAddrW-1:0] RegGreen   = 3'd5;
  localparam logic [CfgAddrW-1:0] RegBlue    = 3'd6;

  // reset values
  localparam logic [ChanW-1:0] MarginReset  = 8'd20;
  localparam logic [RgbW-1:0]  YellowReset  = 24'hFFFF00;
  localparam logic [RgbW-1:0]  MagentaReset = 24'hFF00FF;
  localparam logic [RgbW-1:0]  CyanReset    = 24'h00FFFF;
  localparam logic [RgbW-1:0]  RedReset     = 24'hFF0000;
  localparam logic [RgbW-1:0]  GreenReset   = 24'h00FF00;
  localparam logic [RgbW-1:0]  BlueReset    = 24'h0000FF;

  // mean thresholds folded into the channel sum (mean = sum / 3)
  // mean < 85   <=> sum < 255
  // mean > 170  <=> sum >= 513
  // mean < 170  <=> sum < 510
  localparam logic [SumW-1:0] SumDarkLimit  = 10'd255;
  localparam logic [SumW-1:0] SumLightLimit = 10'd513;
  localparam logic [SumW-1:0] SumBwLimit    = 10'd510;

  localparam logic [ChanW-1:0] GrayLevel  = 8'd127;
  localparam logic [ChanW-1:0] ChanMax    = 8'd255;
  localparam logic [RgbW-1:0]  HueBlack   = 24'h000000;
  localparam logic [RgbW-1:0]  HueWhite   = 24'hFFFFFF;

  // red in the low byte, matching the stream data layout
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  // palette colors are packed R[23:16] G[15:8] B[7:0]
  typedef struct packed {
    logic [ChanW-1:0] margin;
    logic [RgbW-1:0]  yellow_rgb;
    logic [RgbW-1:0]  magenta_rgb;
    logic [RgbW-1:0]  cyan_rgb;
    logic [RgbW-1:0]  red_rgb;
    logic [RgbW-1:0]  green_rgb;
    logic [RgbW-1:0]  blue_rgb;
  } cfg_t;

endpackage

@@ rtl/core/ptp_cfg_regs.sv @@
// Configuration registers of the posterizer: margin and six palette colors.
// Depends on ptp_pkg.
module ptp_cfg_regs import ptp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [RgbW-1:0]     cfg_wdata,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.margin      <= MarginReset;
      cfg.yellow_rgb  <= YellowReset;
      cfg.magenta_rgb <= MagentaReset;
      cfg.cyan_rgb    <= CyanReset;
      cfg.red_rgb     <= RedReset;
      cfg.green_rgb   <= GreenReset;
      cfg.blue_rgb    <= BlueReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegMargin:  cfg.margin      <= cfg_wdata[ChanW-1:0];
        RegYellow:  cfg.yellow_rgb  <= cfg_wdata;
        RegMagenta: cfg.magenta_rgb <= cfg_wdata;
        RegCyan:    cfg.cyan_rgb    <= cfg_wdata;
        RegRed:     cfg.red_rgb     <= cfg_wdata;
        RegGreen:   cfg.green_rgb   <= cfg_wdata;
        RegBlue:    cfg.blue_rgb    <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

@@ rtl/core/ptp_posterize.sv @@
// Combinational shade/hue classification and saturating mix for one pixel.
// Depends on ptp_pkg.
module ptp_posterize import ptp_pkg::*; (
  input  pixel_t pix,
  input  cfg_t   cfg,
  output pixel_t res
);

  logic [SumW-1:0]  sum;
  logic [ChanW-1:0] shade;
  logic [ChanW-1:0] d_rg, d_gb, d_br;
  logic             near_rg, near_gb, near_br;
  logic [RgbW-1:0]  bw;
  logic [RgbW-1:0]  hue;
  logic [ChanW:0]   s_r, s_g, s_b;

  assign sum = SumW'(pix.red) + SumW'(pix.green) + SumW'(pix.blue);

  always_comb begin
    if (sum < SumDarkLimit) begin
      shade = '0;
    end else if (sum >= SumLightLimit) begin
      shade = ChanMax;
    end else begin
      shade = GrayLevel;
    end
  end

  assign d_rg = (pix.red >= pix.green) ? pix.red - pix.green : pix.green - pix.red;
  assign d_gb = (pix.green >= pix.blue) ? pix.green - pix.blue : pix.blue - pix.green;
  assign d_br = (pix.blue >= pix.red) ? pix.blue - pix.red : pix.red - pix.blue;

  assign near_rg = d_rg <= cfg.margin;
  assign near_gb = d_gb <= cfg.margin;
  assign near_br = d_br <= cfg.margin;

  assign bw = (sum < SumBwLimit) ? HueBlack : HueWhite;

  // first near pair wins; third channel near either member collapses to black/white
  always_comb begin
    if (near_rg) begin
      hue = (near_br || near_gb) ? bw : cfg.yellow_rgb;
    end else if (near_gb) begin
      hue = (near_rg || near_br) ? bw : cfg.magenta_rgb;
    end else if (near_br) begin
      hue = (near_gb || near_rg) ? bw : cfg.cyan_rgb;
    end else if (pix.red >= pix.green && pix.red >= pix.blue) begin
      hue = cfg.red_rgb;
    end else if (pix.green >= pix.blue) begin
      hue = cfg.green_rgb;
    end else begin
      hue = cfg.blue_rgb;
    end
  end

  assign s_r = {1'b0, shade} + {1'b0, hue[23:16]};
  assign s_g = {1'b0, shade} + {1'b0, hue[15:8]};
  assign s_b = {1'b0, shade} + {1'b0, hue[7:0]};

  assign res.red   = s_r[ChanW] ? ChanMax : s_r[ChanW-1:0];
  assign res.green = s_g[ChanW] ? ChanMax : s_g[ChanW-1:0];
  assign res.blue  = s_b[ChanW] ? ChanMax : s_b[ChanW-1:0];

endmodule

@@ rtl/core/pixel_tone_and_hue_posterizer.sv @@
// Top level of the pixel tone and hue posterizer: stream ports, pipeline control.
// Depends on ptp_pkg, ptp_cfg_regs and ptp_posterize.
//
// Maps each RGB request to one posterized RGB pixel: a shade (black, gray 127
// or white, from the channel mean) plus a hue (a palette color picked by the
// near channel pairs or the dominant channel), saturated per channel at 255.
// The block takes one pixel per clock while the output is not stalled. The
// edge that accepts a request loads the input register; the result register
// then loads the classified pixel once the result stage is free and drives it
// on m_tdata. The two register stages (input register, then result register)
// sit around the single classification pass. Each stage has its own enable, so
// a stalled output still leaves room for one more request before s_tready
// drops. Margin and palette sit in registers written through
// cfg_we/cfg_addr/cfg_wdata; write them only while the pipeline is empty. The
// configuration registers take their default values on rst and both valid
// flags clear; the pixel data registers are not reset.
module pixel_tone_and_hue_posterizer import ptp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input pixel stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [RgbW-1:0]     s_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  // output pixel stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RgbW-1:0]     m_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  // configuration writes
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [RgbW-1:0]     cfg_wdata
);

  cfg_t   cfg;
  pixel_t in_pix;
  pixel_t res;
  pixel_t out_pix;
  logic   in_valid;
  logic   out_free;

  ptp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // result stage can load when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  // input stage can load when empty or moving into the result stage
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pix <= pixel_t'(s_tdata);
    end
  end

  ptp_posterize u_post (
    .pix (in_pix),
    .cfg (cfg),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && out_free) begin
      out_pix <= res;
    end
  end

  assign m_tdata = out_pix;

  // an accepted request always lands in the input stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted request not held in input stage");

  // a staged pixel moves to the output when the result stage is free
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_free) |=> m_tvalid)
    else $error("staged pixel lost on the way to the output");

  // draining with nothing staged empties the output
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (!in_valid && m_tvalid && m_tready) |=> !m_tvalid)
    else $error("output repeated after drain");

  // an empty input stage never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled while empty");

  // nothing valid right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_valid))
    else $error("valid set after reset");

endmodule

@@ tb/sv/ptp_posterize_checker.sv @@
// Checker for the pixel tone and hue posterizer: watches the pixel streams and the
// configuration port, predicts each output pixel and compares it on arrival.
// Depends on ptp_pkg.
module ptp_posterize_checker import ptp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [RgbW-1:0]     s_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [RgbW-1:0]     m_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [RgbW-1:0]     cfg_wdata,
  output int                  error_count,
  output int                  pixels_in_flight
);

  localparam int ChanCount = 3;
  localparam int DarkMean  = 85;
  localparam int LightMean = 170;

  cfg_t   regs;
  pixel_t expected_pixels[$];
  int     errors = 0;
  string  chan_name[ChanCount] = '{"out_red", "out_green", "out_blue"};

  function automatic logic near_match(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                      logic [ChanW-1:0] margin);
    logic [ChanW-1:0] diff;
    diff = (a >= b) ? a - b : b - a;
    return diff <= margin;
  endfunction

  function automatic logic [ChanW-1:0] sat_channel(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    logic [ChanW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ChanW] ? ChanMax : s[ChanW-1:0];
  endfunction

  // hue as packed R[23:16] G[15:8] B[7:0]
  function automatic logic [RgbW-1:0] pick_hue(pixel_t p, cfg_t c, logic [SumW-1:0] mean);
    logic [RgbW-1:0] mono;
    logic            rg, gb, br;
    mono = (mean < LightMean) ? HueBlack : HueWhite;
    rg   = near_match(p.red, p.green, c.margin);
    gb   = near_match(p.green, p.blue, c.margin);
    br   = near_match(p.blue, p.red, c.margin);
    if (rg) return (br || gb) ? mono : c.yellow_rgb;
    if (gb) return (rg || br) ? mono : c.magenta_rgb;
    if (br) return (gb || rg) ? mono : c.cyan_rgb;
    if (p.red >= p.green && p.red >= p.blue) return c.red_rgb;
    if (p.green >= p.blue) return c.green_rgb;
    return c.blue_rgb;
  endfunction

  function automatic pixel_t posterize_pixel(pixel_t p, cfg_t c);
    logic [SumW-1:0]  sum, mean;
    logic [ChanW-1:0] shade;
    logic [RgbW-1:0]  hue;
    pixel_t           q;
    sum   = SumW'(p.red) + SumW'(p.green) + SumW'(p.blue);
    mean  = SumW'(sum / ChanCount);
    shade = (mean < DarkMean) ? '0 : (mean > LightMean) ? ChanMax : GrayLevel;
    hue   = pick_hue(p, c, mean);
    q.red   = sat_channel(shade, hue[23:16]);
    q.green = sat_channel(shade, hue[15:8]);
    q.blue  = sat_channel(shade, hue[7:0]);
    return q;
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    pixel_t got;
    if (rst) begin
      regs <= '{margin: MarginReset, yellow_rgb: YellowReset, magenta_rgb: MagentaReset,
                cyan_rgb: CyanReset, red_rgb: RedReset, green_rgb: GreenReset,
                blue_rgb: BlueReset};
      expected_pixels.delete();
    end else begin
      // results first: a pixel accepted at this edge cannot come out at it
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected output pixel, expected none, actual %h", $time, got);
        end else begin
          want = expected_pixels.pop_front();
          for (int i = 0; i < ChanCount; i++) begin
            if (got[ChanW*i +: ChanW] !== want[ChanW*i +: ChanW]) begin
              errors++;
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan_name[i],
                       want[ChanW*i +: ChanW], got[ChanW*i +: ChanW]);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_pixels.push_back(posterize_pixel(s_tdata, regs));
      if (cfg_we) begin
        case (cfg_addr)
          RegMargin:  regs.margin      <= cfg_wdata[ChanW-1:0];
          RegYellow:  regs.yellow_rgb  <= cfg_wdata;
          RegMagenta: regs.magenta_rgb <= cfg_wdata;
          RegCyan:    regs.cyan_rgb    <= cfg_wdata;
          RegRed:     regs.red_rgb     <= cfg_wdata;
          RegGreen:   regs.green_rgb   <= cfg_wdata;
          RegBlue:    regs.blue_rgb    <= cfg_wdata;
          default: ;
        endcase
      end
    end
    pixels_in_flight <= expected_pixels.size();
    error_count      <= errors;
  end

endmodule

@@ tb/sv/pixel_tone_and_hue_posterizer_test.sv @@
// Testbench top for the pixel tone and hue posterizer: clock, reset, stimulus and verdict.
// Depends on ptp_pkg, the block itself and ptp_posterize_checker.
module pixel_tone_and_hue_posterizer_test;
  import ptp_pkg::*;

  localparam int IdlePercent   = 11;    // chance of a gap or stall per cycle
  localparam int RandomPixels  = 1350;
  localparam int PhaseCount    = 6;
  localparam int PhasePixels   = RandomPixels / PhaseCount;
  localparam int QuietPhase    = 2;     // no gaps or stalls on either side
  localparam int DrainPhase    = 3;     // sender also drains mid-phase
  localparam int WatchdogLimit = 5000;
  localparam int TailCycles    = 4;     // two-stage pipeline plus slack

  // index past the register list; the block must ignore writes to it
  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [RgbW-1:0]     s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [RgbW-1:0]     m_tdata;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [RgbW-1:0]     cfg_wdata = '0;

  logic quiet        = 1'b0;
  int   stall_cycles = 0;
  int   error_count;
  int   pixels_in_flight;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pixel_tone_and_hue_posterizer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ptp_posterize_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .error_count      (error_count),
    .pixels_in_flight (pixels_in_flight)
  );

  // Receiver: random stalls, none while quiet.
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= IdlePercent);
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("pixel_tone_and_hue_posterizer_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic pixel_t rgb(int r, int g, int b);
    pixel_t p;
    p.red   = ChanW'(r);
    p.green = ChanW'(g);
    p.blue  = ChanW'(b);
    return p;
  endfunction

  function automatic int clamp_chan(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Random pixel, weighted toward the interesting regions for the current margin:
  // chains of near channels, one near pair with a free third channel (sometimes
  // just past the margin), the mean thresholds, and plain noise.
  function automatic pixel_t random_pixel(int margin);
    int ch[3];
    int edges[9] = '{0, 1, 84, 85, 127, 170, 171, 254, 255};
    int bases[5] = '{84, 85, 169, 170, 171};
    int base, a, b, d;
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 4))
      0: for (int i = 0; i < 3; i++) ch[i] = $urandom_range(0, 255);
      1: for (int i = 0; i < 3; i++) ch[i] = clamp_chan(base + $urandom_range(0, 2 * margin) - margin);
      2: begin
        a = $urandom_range(0, 2);
        b = (a + $urandom_range(1, 2)) % 3;
        d = ($urandom_range(0, 3) == 0) ? margin + 1 : $urandom_range(0, margin);
        ch[0] = $urandom_range(0, 255);
        ch[1] = $urandom_range(0, 255);
        ch[2] = $urandom_range(0, 255);
        ch[a] = base;
        ch[b] = $urandom_range(0, 1) ? clamp_chan(base + d) : clamp_chan(base - d);
      end
      3: for (int i = 0; i < 3; i++) ch[i] = edges[$urandom_range(0, 8)];
      default: begin
        base = bases[$urandom_range(0, 4)];
        for (int i = 0; i < 3; i++) ch[i] = base + $urandom_range(0, 2) - 1;
      end
    endcase
    return rgb(ch[0], ch[1], ch[2]);
  endfunction

  // One request; random gaps before it unless quiet.
  task automatic send_pixel(input pixel_t p);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sender holds off until the checker has seen every result.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight != 0) @(posedge clk);
  endtask

  // All seven registers, then one write to the unused index. Upper bits of the
  // margin write carry junk that the block must drop.
  task automatic write_config(input cfg_t c);
    logic [CfgAddrW-1:0] addr;
    for (int i = 0; i <= int'(RegUnused); i++) begin
      addr     = CfgAddrW'(i);
      cfg_we   <= 1'b1;
      cfg_addr <= addr;
      case (addr)
        RegMargin:  cfg_wdata <= {16'($urandom), c.margin};
        RegYellow:  cfg_wdata <= c.yellow_rgb;
        RegMagenta: cfg_wdata <= c.magenta_rgb;
        RegCyan:    cfg_wdata <= c.cyan_rgb;
        RegRed:     cfg_wdata <= c.red_rgb;
        RegGreen:   cfg_wdata <= c.green_rgb;
        RegBlue:    cfg_wdata <= c.blue_rgb;
        default:    cfg_wdata <= RgbW'($urandom);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t phase_setting(int phase);
    cfg_t c;
    c.margin      = ChanW'($urandom);
    c.yellow_rgb  = RgbW'($urandom);
    c.magenta_rgb = RgbW'($urandom);
    c.cyan_rgb    = RgbW'($urandom);
    c.red_rgb     = RgbW'($urandom);
    c.green_rgb   = RgbW'($urandom);
    c.blue_rgb    = RgbW'($urandom);
    case (phase)
      0: c.margin = '0;                            // only exact matches are near
      1: c = '{margin: ChanMax, default: '0};      // everything near, black palette
      2: begin
        c = '{margin: '0, default: HueWhite};      // white palette saturates every palette hue
        c.margin = ChanW'($urandom_range(0, 40));
      end
      4: c = '{margin: MarginReset, yellow_rgb: YellowReset, magenta_rgb: MagentaReset,
               cyan_rgb: CyanReset, red_rgb: RedReset, green_rgb: GreenReset,
               blue_rgb: BlueReset};
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    cfg_t setting;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset margin (20) and palette.
    send_pixel(rgb(0, 0, 0));          // all near, dark: black
    send_pixel(rgb(255, 255, 255));    // all near, light: white
    send_pixel(rgb(255, 0, 0));        // green-blue pair near, red far: magenta
    send_pixel(rgb(0, 0, 255));        // red-green pair: yellow
    send_pixel(rgb(200, 100, 0));      // red dominates
    send_pixel(rgb(0, 200, 100));      // green dominates
    send_pixel(rgb(100, 0, 200));      // blue dominates
    send_pixel(rgb(255, 180, 100));    // red dominates, white shade saturates
    send_pixel(rgb(200, 200, 0));      // yellow on gray
    send_pixel(rgb(0, 200, 210));      // magenta
    send_pixel(rgb(200, 0, 190));      // cyan
    send_pixel(rgb(100, 120, 140));    // near chain, mean below 170: black hue
    send_pixel(rgb(250, 240, 230));    // near chain, bright: white hue
    send_pixel(rgb(100, 120, 200));    // difference exactly at margin: yellow
    send_pixel(rgb(100, 121, 200));    // one past margin: blue dominates
    send_pixel(rgb(84, 85, 85));       // mean 84: black shade
    send_pixel(rgb(85, 85, 85));       // mean 85: gray shade
    send_pixel(rgb(170, 170, 169));    // mean 169: black hue on gray
    send_pixel(rgb(170, 170, 170));    // mean 170: white hue on gray
    send_pixel(rgb(171, 171, 170));    // mean 170 with sum 512
    send_pixel(rgb(171, 171, 171));    // mean 171: white shade
    send_pixel(rgb(255, 0, 255));      // blue-red exact, green far: cyan

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      setting = phase_setting(phase);
      write_config(setting);
      quiet <= (phase == QuietPhase);
      for (int i = 0; i < PhasePixels; i++) begin
        if (phase == DrainPhase && i == PhasePixels / 2)
          wait_drained();
        send_pixel(random_pixel(setting.margin));
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0)
      $display("pixel_tone_and_hue_posterizer_test: done, clean");
    else
      $display("pixel_tone_and_hue_posterizer_test: done, errors");
    $finish;
  end

endmodule
